FILE: src/onewire_uart_temp_reader_defines.svh
// Assertion macros shared by the reader RTL.
`ifndef ONEWIRE_UART_TEMP_READER_DEFINES_SVH
`define ONEWIRE_UART_TEMP_READER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define OWTR_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("owtr check failed");

// Check that cons holds in the cycle after ante.
`define OWTR_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("owtr next-cycle check failed");

`endif

FILE: src/owtr_pkg.sv
package owtr_pkg;

    localparam int SCRATCH_BYTES = 9;
    localparam int WAIT_WIDTH    = 24;
    localparam int CFG_WIDTH     = 24;
    localparam int PADDR_WIDTH   = 3;

    localparam logic [CFG_WIDTH-1:0] CONVERT_WAIT_RESET = 24'd35000;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_RX_BYTE = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_REPLY = 2'd1;
    localparam logic [1:0] ST_NO_PRES  = 2'd2;
    localparam logic [1:0] ST_CRC_ERR  = 2'd3;

    localparam logic [7:0] BYTE_RESET   = 8'hE0;
    localparam logic [7:0] BYTE_SLOT_1  = 8'hFF;
    localparam logic [7:0] BYTE_SLOT_0  = 8'hF0;
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;
    localparam logic [7:0] CRC_POLY     = 8'h8C;
    localparam logic [15:0] RAW_NEG_LIMIT = 16'h07D0;

    localparam logic [6:0] CMD_BITS  = 7'd16;
    localparam logic [6:0] READ_BITS = 7'(SCRATCH_BYTES * 8);
    localparam logic [3:0] CRC_BYTES = 4'(SCRATCH_BYTES - 1);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_RST1  = 4'd1,
        PH_CONV  = 4'd2,
        PH_WAIT  = 4'd3,
        PH_RST2  = 4'd4,
        PH_RDCMD = 4'd5,
        PH_READ  = 4'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] temperature;
        logic       negative;
    } t_temp;

    function automatic logic [7:0] cmd_slot(input logic [7:0] second, input logic [6:0] idx);
        logic [7:0] cmd;
        cmd = (idx < 7'd8) ? CMD_SKIP_ROM : second;
        return cmd[idx[2:0]] ? BYTE_SLOT_1 : BYTE_SLOT_0;
    endfunction

    function automatic t_temp convert_temp(input logic [15:0] raw);
        t_temp      res;
        logic [7:0] lo;
        lo = ~raw[11:4];
        if (raw < RAW_NEG_LIMIT) begin
            res.temperature = {1'b0, raw[10:4]};
            res.negative    = 1'b0;
        end else begin
            res.temperature = lo[7] ? (~lo + 8'd1) : lo;
            res.negative    = 1'b1;
        end
        return res;
    endfunction

endpackage

FILE: src/onewire_uart_temp_reader.sv
// One-wire temperature reader that drives the bus through a UART.
// Input channel (i_in_valid / o_in_stall) carries events: start read, UART
// byte received (with i_rx_byte), time tick, receive timeout. Output channel
// (o_out_valid / i_out_stall) carries at most one item per event: either a
// byte to transmit with its baud select, or the final done item with status,
// temperature magnitude and sign.
// Each event is handled by the phase logic and lands in the output register
// at the accepting edge, and a new event is taken every cycle while the
// output register is empty or being drained. When the receiver stalls a
// pending item, the input is stalled until the item is taken; the item
// holds steady meanwhile.
// Register convert_wait_ticks (APB byte address 0, 24 bits) sets the ticks
// waited after the convert command; it resets to 35000.
// Synchronous reset returns the sequencer to idle and empties the output.
module onewire_uart_temp_reader (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_action,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_tx_valid,
    output logic [7:0]                        o_tx_byte,
    output logic                              o_baud_fast,
    output logic                              o_done_res,
    output logic [1:0]                        o_status,
    output logic [7:0]                        o_temperature,
    output logic                              o_negative,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [owtr_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import owtr_pkg::*;

    `include "onewire_uart_temp_reader_defines.svh"

    logic [CFG_WIDTH-1:0]  r_wait_ticks;
    t_phase                r_phase, n_phase;
    logic [6:0]            r_bit_cnt, n_bit_cnt;
    logic [7:0]            r_shift, n_shift;
    logic [7:0]            r_temp_lo, n_temp_lo;
    logic [7:0]            r_temp_hi, n_temp_hi;
    logic [7:0]            r_crc, n_crc;
    logic [WAIT_WIDTH-1:0] r_wait_cnt, n_wait_cnt;

    logic       r_out_valid, n_out_valid;
    logic       r_tx_valid, n_tx_valid;
    logic [7:0] r_tx_byte, n_tx_byte;
    logic       r_baud_fast, n_baud_fast;
    logic       r_done, n_done;
    logic [1:0] r_status, n_status;
    logic [7:0] r_temp, n_temp;
    logic       r_neg, n_neg;

    logic                  in_accept;
    logic                  start_accept;
    logic                  cfg_write;
    logic                  rx_bit;
    logic [6:0]            bit_next;
    logic [7:0]            shift_set;
    logic [7:0]            crc_step;
    logic [WAIT_WIDTH-1:0] wait_inc;
    logic [7:0]            cmd_second;
    t_temp                 temp_conv;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign start_accept = in_accept && r_phase == PH_IDLE && i_action == ACT_START;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr == '0) ? {{(32 - CFG_WIDTH){1'b0}}, r_wait_ticks} : 32'd0;

    assign rx_bit     = (i_rx_byte == BYTE_SLOT_1);
    assign bit_next   = r_bit_cnt + 7'd1;
    assign shift_set  = r_shift | ({7'd0, rx_bit} << r_bit_cnt[2:0]);
    assign crc_step   = {1'b0, r_crc[7:1]} ^ (((r_crc[0] ^ rx_bit)) ? CRC_POLY : 8'd0);
    assign wait_inc   = (r_wait_cnt == '1) ? r_wait_cnt : r_wait_cnt + 1'b1;
    assign cmd_second = (r_phase == PH_CONV) ? CMD_CONVERT : CMD_READ_SP;
    assign temp_conv  = convert_temp({r_temp_hi, r_temp_lo});

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_temp_lo   = r_temp_lo;
        n_temp_hi   = r_temp_hi;
        n_crc       = r_crc;
        n_wait_cnt  = r_wait_cnt;
        n_out_valid = 1'b0;
        n_tx_valid  = 1'b0;
        n_tx_byte   = 8'd0;
        n_baud_fast = 1'b0;
        n_done      = 1'b0;
        n_status    = ST_OK;
        n_temp      = 8'd0;
        n_neg       = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_action == ACT_START) begin
                    n_phase     = PH_RST1;
                    n_out_valid = 1'b1;
                    n_tx_valid  = 1'b1;
                    n_tx_byte   = BYTE_RESET;
                end
            end
            PH_RST1, PH_RST2: begin
                if (i_action == ACT_TIMEOUT) begin
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_done      = 1'b1;
                    n_status    = ST_NO_REPLY;
                end else if (i_action == ACT_RX_BYTE) begin
                    n_out_valid = 1'b1;
                    if (i_rx_byte == BYTE_RESET) begin
                        n_phase  = PH_IDLE;
                        n_done   = 1'b1;
                        n_status = ST_NO_PRES;
                    end else begin
                        n_phase     = (r_phase == PH_RST1) ? PH_CONV : PH_RDCMD;
                        n_bit_cnt   = 7'd0;
                        n_tx_valid  = 1'b1;
                        n_tx_byte   = cmd_slot(CMD_SKIP_ROM, 7'd0);
                        n_baud_fast = 1'b1;
                    end
                end
            end
            PH_CONV, PH_RDCMD: begin
                if (i_action == ACT_TIMEOUT) begin
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_done      = 1'b1;
                    n_status    = ST_NO_REPLY;
                end else if (i_action == ACT_RX_BYTE) begin
                    if (bit_next < CMD_BITS) begin
                        n_bit_cnt   = bit_next;
                        n_out_valid = 1'b1;
                        n_tx_valid  = 1'b1;
                        n_tx_byte   = cmd_slot(cmd_second, bit_next);
                        n_baud_fast = 1'b1;
                    end else begin
                        n_bit_cnt = 7'd0;
                        if (r_phase == PH_CONV) begin
                            n_phase    = PH_WAIT;
                            n_wait_cnt = '0;
                        end else begin
                            n_phase     = PH_READ;
                            n_shift     = 8'd0;
                            n_crc       = 8'd0;
                            n_out_valid = 1'b1;
                            n_tx_valid  = 1'b1;
                            n_tx_byte   = BYTE_SLOT_1;
                            n_baud_fast = 1'b1;
                        end
                    end
                end
            end
            PH_WAIT: begin
                if (i_action == ACT_TICK) begin
                    n_wait_cnt = wait_inc;
                    if (wait_inc >= WAIT_WIDTH'(r_wait_ticks) || wait_inc == '1) begin
                        n_phase     = PH_RST2;
                        n_out_valid = 1'b1;
                        n_tx_valid  = 1'b1;
                        n_tx_byte   = BYTE_RESET;
                    end
                end
            end
            PH_READ: begin
                if (i_action == ACT_TIMEOUT) begin
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_done      = 1'b1;
                    n_status    = ST_NO_REPLY;
                end else if (i_action == ACT_RX_BYTE) begin
                    n_shift   = shift_set;
                    n_bit_cnt = bit_next;
                    if (r_bit_cnt[6:3] < CRC_BYTES) begin
                        n_crc = crc_step;
                    end
                    n_out_valid = 1'b1;
                    n_tx_valid  = 1'b1;
                    n_tx_byte   = BYTE_SLOT_1;
                    n_baud_fast = 1'b1;
                    if (bit_next[2:0] == 3'd0) begin
                        if (r_bit_cnt[6:3] == 4'd0) begin
                            n_temp_lo = shift_set;
                        end else if (r_bit_cnt[6:3] == 4'd1) begin
                            n_temp_hi = shift_set;
                        end
                        if (bit_next >= READ_BITS) begin
                            n_phase     = PH_IDLE;
                            n_tx_valid  = 1'b0;
                            n_tx_byte   = 8'd0;
                            n_baud_fast = 1'b0;
                            n_done      = 1'b1;
                            if (n_crc != shift_set) begin
                                n_status = ST_CRC_ERR;
                            end else begin
                                n_temp = temp_conv.temperature;
                                n_neg  = temp_conv.negative;
                            end
                        end else begin
                            n_shift = 8'd0;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= CONVERT_WAIT_RESET;
            r_phase      <= PH_IDLE;
            r_bit_cnt    <= 7'd0;
            r_shift      <= 8'd0;
            r_temp_lo    <= 8'd0;
            r_temp_hi    <= 8'd0;
            r_crc        <= 8'd0;
            r_wait_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write && paddr == '0) begin
                r_wait_ticks <= pwdata[CFG_WIDTH-1:0];
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_bit_cnt   <= n_bit_cnt;
                r_shift     <= n_shift;
                r_temp_lo   <= n_temp_lo;
                r_temp_hi   <= n_temp_hi;
                r_crc       <= n_crc;
                r_wait_cnt  <= n_wait_cnt;
                r_out_valid <= n_out_valid;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_out_valid) begin
            r_tx_valid  <= n_tx_valid;
            r_tx_byte   <= n_tx_byte;
            r_baud_fast <= n_baud_fast;
            r_done      <= n_done;
            r_status    <= n_status;
            r_temp      <= n_temp;
            r_neg       <= n_neg;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_baud_fast   = r_baud_fast;
    assign o_done_res    = r_done;
    assign o_status      = r_status;
    assign o_temperature = r_temp;
    assign o_negative    = r_neg;

    `OWTR_CHECK(a_one_kind, o_out_valid, o_tx_valid != o_done_res)
    `OWTR_CHECK(a_done_idle, o_out_valid && o_done_res, r_phase == PH_IDLE)
    `OWTR_CHECK(a_slow_is_reset, o_out_valid && o_tx_valid && !o_baud_fast, o_tx_byte == BYTE_RESET)
    `OWTR_CHECK_NEXT(a_start_sends, start_accept, o_out_valid && o_tx_valid)

endmodule

FILE: tb/onewire_reply_checker.sv
module onewire_reply_checker #(
    parameter logic [owtr_pkg::PADDR_WIDTH-1:0] WAIT_ADDR = '0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [1:0]                       i_action,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_tx_valid,
    input  logic [7:0]                       i_tx_byte,
    input  logic                             i_baud_fast,
    input  logic                             i_done_res,
    input  logic [1:0]                       i_status,
    input  logic [7:0]                       i_temperature,
    input  logic                             i_negative,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [owtr_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                      pwdata,
    input  logic                             pready,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import owtr_pkg::*;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       baud_fast;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] temperature;
        logic       negative;
    } t_ow_reply;

    t_ow_reply                expected_replies[$];
    t_phase                   seq_phase;
    logic [6:0]               bit_idx;
    logic [7:0]               shift_acc;
    logic [7:0]               temp_lo;
    logic [7:0]               temp_hi;
    logic [7:0]               crc_acc;
    logic [WAIT_WIDTH-1:0]    tick_count;
    logic [CFG_WIDTH-1:0]     wait_limit;

    function automatic t_ow_reply tx_reply(input logic [7:0] b, input logic fast);
        t_ow_reply r;
        r = '0;
        r.tx_valid  = 1'b1;
        r.tx_byte   = b;
        r.baud_fast = fast;
        return r;
    endfunction

    function automatic t_ow_reply done_reply(input logic [1:0] st, input logic [7:0] t,
                                             input logic neg);
        t_ow_reply r;
        r = '0;
        r.done_res    = 1'b1;
        r.status      = st;
        r.temperature = t;
        r.negative    = neg;
        return r;
    endfunction

    function automatic logic [7:0] command_slot(input logic [7:0] cmd_hi, input logic [6:0] n);
        logic [15:0] pair;
        pair = {cmd_hi, CMD_SKIP_ROM};
        return pair[n[3:0]] ? BYTE_SLOT_1 : BYTE_SLOT_0;
    endfunction

    function automatic t_ow_reply temperature_reply();
        logic [15:0] raw;
        logic [15:0] mag;
        logic [7:0]  lo;
        if (crc_acc != shift_acc) begin
            return done_reply(ST_CRC_ERR, 8'h00, 1'b0);
        end
        raw = {temp_hi, temp_lo};
        if (raw < RAW_NEG_LIMIT) begin
            return done_reply(ST_OK, {1'b0, raw[10:4]}, 1'b0);
        end
        mag = (16'hFFFF - raw) >> 4;
        lo  = mag[7:0];
        return done_reply(ST_OK, lo[7] ? (8'd0 - lo) : lo, 1'b1);
    endfunction

    task automatic end_sequence(input t_ow_reply r);
        expected_replies.push_back(r);
        seq_phase = PH_IDLE;
    endtask

    task automatic log_miss(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("%0t: reply %s got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic apply_event(input logic [1:0] act, input logic [7:0] rx);
        logic       bit_in;
        logic [3:0] byte_n;
        logic       feedback;
        case (seq_phase)
            PH_IDLE: begin
                if (act == ACT_START) begin
                    seq_phase = PH_RST1;
                    expected_replies.push_back(tx_reply(BYTE_RESET, 1'b0));
                end
            end
            PH_RST1, PH_RST2: begin
                if (act == ACT_TIMEOUT) begin
                    end_sequence(done_reply(ST_NO_REPLY, 8'h00, 1'b0));
                end else if (act == ACT_RX_BYTE) begin
                    if (rx == BYTE_RESET) begin
                        end_sequence(done_reply(ST_NO_PRES, 8'h00, 1'b0));
                    end else begin
                        seq_phase = (seq_phase == PH_RST1) ? PH_CONV : PH_RDCMD;
                        bit_idx   = '0;
                        expected_replies.push_back(tx_reply(command_slot(
                            (seq_phase == PH_CONV) ? CMD_CONVERT : CMD_READ_SP, bit_idx), 1'b1));
                    end
                end
            end
            PH_CONV, PH_RDCMD: begin
                if (act == ACT_TIMEOUT) begin
                    end_sequence(done_reply(ST_NO_REPLY, 8'h00, 1'b0));
                end else if (act == ACT_RX_BYTE) begin
                    bit_idx = bit_idx + 7'd1;
                    if (bit_idx < CMD_BITS) begin
                        expected_replies.push_back(tx_reply(command_slot(
                            (seq_phase == PH_CONV) ? CMD_CONVERT : CMD_READ_SP, bit_idx), 1'b1));
                    end else begin
                        bit_idx = '0;
                        if (seq_phase == PH_CONV) begin
                            seq_phase  = PH_WAIT;
                            tick_count = '0;
                        end else begin
                            seq_phase = PH_READ;
                            shift_acc = '0;
                            crc_acc   = '0;
                            expected_replies.push_back(tx_reply(BYTE_SLOT_1, 1'b1));
                        end
                    end
                end
            end
            PH_WAIT: begin
                if (act == ACT_TICK) begin
                    if (tick_count != '1) begin
                        tick_count = tick_count + 1'b1;
                    end
                    if (tick_count >= wait_limit || tick_count == '1) begin
                        seq_phase = PH_RST2;
                        expected_replies.push_back(tx_reply(BYTE_RESET, 1'b0));
                    end
                end
            end
            PH_READ: begin
                if (act == ACT_TIMEOUT) begin
                    end_sequence(done_reply(ST_NO_REPLY, 8'h00, 1'b0));
                end else if (act == ACT_RX_BYTE) begin
                    bit_in = (rx == BYTE_SLOT_1);
                    byte_n = bit_idx[6:3];
                    if (bit_in) begin
                        shift_acc[bit_idx[2:0]] = 1'b1;
                    end
                    if (byte_n < CRC_BYTES) begin
                        feedback = crc_acc[0] ^ bit_in;
                        crc_acc  = crc_acc >> 1;
                        if (feedback) begin
                            crc_acc = crc_acc ^ CRC_POLY;
                        end
                    end
                    bit_idx = bit_idx + 7'd1;
                    if (bit_idx[2:0] == 3'd0 && bit_idx >= READ_BITS) begin
                        end_sequence(temperature_reply());
                    end else begin
                        if (bit_idx[2:0] == 3'd0) begin
                            if (byte_n == 4'd0) begin
                                temp_lo = shift_acc;
                            end else if (byte_n == 4'd1) begin
                                temp_hi = shift_acc;
                            end
                            shift_acc = '0;
                        end
                        expected_replies.push_back(tx_reply(BYTE_SLOT_1, 1'b1));
                    end
                end
            end
            default: begin
                seq_phase = PH_IDLE;
            end
        endcase
    endtask

    task automatic check_reply();
        t_ow_reply want;
        if (expected_replies.size() == 0) begin
            log_miss("with nothing pending", i_tx_byte, 8'h00);
            return;
        end
        want = expected_replies.pop_front();
        if (i_tx_valid !== want.tx_valid) begin
            log_miss("tx_valid", 8'(i_tx_valid), 8'(want.tx_valid));
        end
        if (i_tx_byte !== want.tx_byte)         log_miss("tx_byte", i_tx_byte, want.tx_byte);
        if (i_baud_fast !== want.baud_fast) begin
            log_miss("baud_fast", 8'(i_baud_fast), 8'(want.baud_fast));
        end
        if (i_done_res !== want.done_res) begin
            log_miss("done_res", 8'(i_done_res), 8'(want.done_res));
        end
        if (i_status !== want.status) begin
            log_miss("status", 8'(i_status), 8'(want.status));
        end
        if (i_temperature !== want.temperature) begin
            log_miss("temperature", i_temperature, want.temperature);
        end
        if (i_negative !== want.negative) begin
            log_miss("negative", 8'(i_negative), 8'(want.negative));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_replies.delete();
            seq_phase    = PH_IDLE;
            bit_idx      = '0;
            shift_acc    = '0;
            temp_lo      = '0;
            temp_hi      = '0;
            crc_acc      = '0;
            tick_count   = '0;
            wait_limit   = CONVERT_WAIT_RESET;
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_reply();
            end
            if (psel && penable && pwrite && pready && paddr == WAIT_ADDR) begin
                wait_limit = pwdata[CFG_WIDTH-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                apply_event(i_action, i_rx_byte);
            end
        end
        o_pending = expected_replies.size();
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import owtr_pkg::*;

    localparam logic [PADDR_WIDTH-1:0] ADDR_WAIT_TICKS = '0;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 400;

    typedef enum logic [1:0] {
        QUIET_IDLE,
        QUIET_ECHO,
        QUIET_WAIT
    } t_quiet_kind;

    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  rx;
        t_quiet_kind quiet;
    } t_ow_event;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             action;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   tx_valid;
    logic [7:0]             tx_byte;
    logic                   baud_fast;
    logic                   done_res;
    logic [1:0]             status;
    logic [7:0]             temperature;
    logic                   negative;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_WIDTH-1:0] paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    int                     fail_count;
    int                     pending;

    bit                     idle_on;
    bit                     long_hold_req;
    int                     stall_left;
    int                     quiet_cycles;
    int                     counted_items;
    logic [CFG_WIDTH-1:0]   cur_ticks;

    onewire_uart_temp_reader dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (action),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_tx_valid    (tx_valid),
        .o_tx_byte     (tx_byte),
        .o_baud_fast   (baud_fast),
        .o_done_res    (done_res),
        .o_status      (status),
        .o_temperature (temperature),
        .o_negative    (negative),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    onewire_reply_checker #(
        .WAIT_ADDR (ADDR_WAIT_TICKS)
    ) reply_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_action      (action),
        .i_rx_byte     (rx_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_tx_valid    (tx_valid),
        .i_tx_byte     (tx_byte),
        .i_baud_fast   (baud_fast),
        .i_done_res    (done_res),
        .i_status      (status),
        .i_temperature (temperature),
        .i_negative    (negative),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_ow_event make_event(input logic [1:0] act, input logic [7:0] rx,
                                             input t_quiet_kind quiet);
        t_ow_event ev;
        ev.act   = act;
        ev.rx    = rx;
        ev.quiet = quiet;
        return ev;
    endfunction

    function automatic logic [7:0] byte_except(input logic [7:0] skip);
        logic [7:0] b;
        do b = 8'($urandom); while (b == skip);
        return b;
    endfunction

    function automatic logic [7:0] scratch_crc(input logic [8:0][7:0] pad);
        logic [7:0] crc;
        crc = '0;
        for (int i = 0; i < SCRATCH_BYTES - 1; i++) begin
            crc = crc ^ pad[i];
            for (int j = 0; j < 8; j++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 12))
            0:       return 16'h0000;
            1:       return 16'h07CF;
            2:       return 16'h07D0;
            3:       return 16'hFFFF;
            4:       return 16'hF7F0;
            5:       return 16'hF800;
            6:       return 16'h8000;
            7:       return 16'h07FF;
            8, 9:    return 16'($urandom_range(0, 16'h07CF));
            10:      return 16'hFFFF - 16'($urandom_range(0, 16'h0FFF));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_event(input logic [1:0] act, input logic [7:0] rx);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        rx_byte  <= rx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_noise(input t_quiet_kind quiet);
        logic [1:0] act;
        case (quiet)
            QUIET_IDLE: begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_RX_BYTE;
                    1:       act = ACT_TICK;
                    default: act = ACT_TIMEOUT;
                endcase
            end
            QUIET_WAIT: begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_START;
                    1:       act = ACT_RX_BYTE;
                    default: act = ACT_TIMEOUT;
                endcase
            end
            default: begin
                act = $urandom_range(0, 1) ? ACT_START : ACT_TICK;
            end
        endcase
        send_event(act, 8'($urandom));
    endtask

    task automatic set_wait_ticks(input logic [CFG_WIDTH-1:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WAIT_TICKS;
        pwdata  <= {{(32 - CFG_WIDTH){1'b0}}, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_ticks = val;
    endtask

    // Build one read; a fault, if any, replaces the item at stop and ends it there.
    task automatic run_read(input bit early);
        t_ow_event       seq[$];
        t_ow_event       ev;
        logic [8:0][7:0] pad;
        logic [15:0]     raw;
        int              roll;
        int              stop;
        int              wait_n;
        int              rst2_at;
        bit              faulted;
        logic [1:0]      fault_act;
        logic [7:0]      fault_rx;
        roll    = early ? (7 + $urandom_range(0, 1)) : $urandom_range(0, 9);
        faulted = (roll >= 7);
        raw     = pick_raw();
        pad[0]  = raw[7:0];
        pad[1]  = raw[15:8];
        for (int i = 2; i < SCRATCH_BYTES - 1; i++) begin
            pad[i] = 8'($urandom);
        end
        pad[8] = scratch_crc(pad);
        if (roll == 6) begin
            pad[8] = pad[8] ^ byte_except(8'h00);
        end

        seq.push_back(make_event(ACT_START, 8'($urandom), QUIET_IDLE));
        seq.push_back(make_event(ACT_RX_BYTE, byte_except(BYTE_RESET), QUIET_ECHO));
        for (int i = 0; i < CMD_BITS; i++) begin
            seq.push_back(make_event(ACT_RX_BYTE, 8'($urandom), QUIET_ECHO));
        end
        rst2_at = 1;
        if (!early) begin
            wait_n = (cur_ticks == 0) ? 1 : int'(cur_ticks);
            for (int i = 0; i < wait_n; i++) begin
                seq.push_back(make_event(ACT_TICK, 8'($urandom), QUIET_WAIT));
            end
            rst2_at = seq.size();
            seq.push_back(make_event(ACT_RX_BYTE, byte_except(BYTE_RESET), QUIET_ECHO));
            for (int i = 0; i < CMD_BITS; i++) begin
                seq.push_back(make_event(ACT_RX_BYTE, 8'($urandom), QUIET_ECHO));
            end
            for (int i = 0; i < READ_BITS; i++) begin
                seq.push_back(make_event(ACT_RX_BYTE,
                    pad[i / 8][i % 8] ? BYTE_SLOT_1 : byte_except(BYTE_SLOT_1), QUIET_ECHO));
            end
        end

        stop      = seq.size() - 1;
        fault_act = ACT_TIMEOUT;
        fault_rx  = 8'($urandom);
        if (roll == 7) begin
            stop      = (early || $urandom_range(0, 1)) ? 1 : rst2_at;
            fault_act = ACT_RX_BYTE;
            fault_rx  = BYTE_RESET;
        end else if (roll >= 8) begin
            do stop = $urandom_range(1, seq.size() - 1); while (seq[stop].quiet != QUIET_ECHO);
        end

        for (int i = 0; i <= stop; i++) begin
            ev = seq[i];
            if (faulted && i == stop) begin
                ev.act = fault_act;
                ev.rx  = fault_rx;
            end
            if ($urandom_range(0, 15) == 0) begin
                send_noise(ev.quiet);
            end
            send_event(ev.act, ev.rx);
            if (ev.act != ACT_TICK) begin
                counted_items++;
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            send_noise(QUIET_IDLE);
        end
    endtask

    task automatic run_setting(input logic [CFG_WIDTH-1:0] ticks, input bit early,
                               input int n_items);
        int goal;
        set_wait_ticks(ticks);
        goal = counted_items + n_items;
        do run_read(early); while (counted_items < goal);
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_START;
        rx_byte       = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        counted_items = 0;
        cur_ticks     = CONVERT_WAIT_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_event(ACT_TIMEOUT, 8'hFF);
        send_event(ACT_RX_BYTE, 8'h00);
        send_event(ACT_TICK, 8'hFF);
        send_event(ACT_START, 8'h00);
        send_event(ACT_START, 8'hFF);
        send_event(ACT_TICK, 8'h00);
        send_event(ACT_RX_BYTE, BYTE_RESET);
        send_event(ACT_START, 8'h00);
        send_event(ACT_TIMEOUT, 8'h00);
        send_event(ACT_START, 8'h00);
        send_event(ACT_RX_BYTE, 8'hFF);
        send_event(ACT_RX_BYTE, 8'h00);
        send_event(ACT_TIMEOUT, 8'hFF);

        set_wait_ticks(24'd5);
        long_hold_req = 1'b1;
        run_setting(24'd5, 1'b0, 250);
        run_setting(24'd0, 1'b0, 150);
        run_setting(24'hFFFFFF, 1'b1, 100);
        run_setting(24'd1, 1'b0, 150);
        run_setting(CONVERT_WAIT_RESET, 1'b1, 1);
        run_setting(24'($urandom_range(2, 60)), 1'b0, 150);
        idle_on = 1'b0;
        run_setting(24'd1, 1'b0, 150);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
